// ----- rtl/rks_pkg.sv -----
// ----------------------------------------------------------------------------
// rks_pkg
// Shared constants, codes and types of the rotating key substitution cipher.
// ----------------------------------------------------------------------------
package rks_pkg;

  localparam int ALPHA      = 26;
  localparam int KEY_W      = 5;
  localparam int CHAR_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 60;
  localparam int HIGH_W     = 10;
  localparam int QDEPTH_DEF = 2;

  localparam logic [KEY_W-1:0]  LAST_POS = 5'd25;
  localparam logic [CHAR_W-1:0] LETTER_A = 8'h61;
  localparam logic [CHAR_W-1:0] LETTER_Z = 8'h7A;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_MID  = 2'd1,
    REG_KEY_HIGH = 2'd2
  } reg_idx_t;

  // entry i of the key sits at bits 5i..5i+4
  typedef logic [ALPHA-1:0][KEY_W-1:0] key_t;

  typedef struct packed {
    logic              mode;
    logic [CHAR_W-1:0] char_in;
    logic              is_alpha;
    logic [KEY_W-1:0]  offset;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

// ----- rtl/rks_in_if.sv -----
// ----------------------------------------------------------------------------
// rks_in_if
// Input character channel: valid/ready with mode, byte and restart flag.
// ----------------------------------------------------------------------------
interface rks_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] char_in;
  logic       restart;

  modport source (output valid, mode, char_in, restart, input ready);
  modport sink (input valid, mode, char_in, restart, output ready);
endinterface

// ----- rtl/rks_out_if.sv -----
// ----------------------------------------------------------------------------
// rks_out_if
// Result channel: valid/ready with translated byte and letter flag.
// ----------------------------------------------------------------------------
interface rks_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       is_letter;

  modport source (output valid, char_out, is_letter, input ready);
  modport sink (input valid, char_out, is_letter, output ready);
endinterface

// ----- rtl/rks_front.sv -----
// ----------------------------------------------------------------------------
// rks_front
// Accepts characters, tracks the key offset and tags each transaction.
// ----------------------------------------------------------------------------
module rks_front
  import rks_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  rks_in_if.sink   in_ch,
  input  q_stat_t  q_stat,
  output logic     push,
  output item_t    item
);

  logic [KEY_W-1:0] off_r, off_nxt;
  logic [KEY_W-1:0] off_use;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && in_ch.ready;

  assign off_use = in_ch.restart ? '0 : off_r;
  assign off_nxt = (off_use == LAST_POS) ? '0 : off_use + 5'd1;

  always_comb begin
    item.mode     = in_ch.mode;
    item.char_in  = in_ch.char_in;
    item.is_alpha = (in_ch.char_in >= LETTER_A) && (in_ch.char_in <= LETTER_Z);
    item.offset   = off_use;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
    end else if (push) begin
      off_r <= off_nxt;
    end
  end

endmodule

// ----- rtl/rks_queue.sv -----
// ----------------------------------------------------------------------------
// rks_queue
// Small FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module rks_queue
  import rks_pkg::*;
#(
  parameter int QDEPTH = QDEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   head,
  output q_stat_t stat
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  item_t            mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign stat.full  = (cnt_r == CNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

// ----- rtl/rks_back.sv -----
// ----------------------------------------------------------------------------
// rks_back
// Holds the key, translates queued characters into the output register.
// ----------------------------------------------------------------------------
module rks_back
  import rks_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_wr_t cfg,
  input  item_t   head,
  input  q_stat_t q_stat,
  output logic    pop,
  rks_out_if.source out_ch
);

  logic [CFG_DATA_W-1:0] key_low_r, key_mid_r;
  logic [HIGH_W-1:0]     key_high_r;
  key_t                  key;

  logic                  out_valid_r;
  logic [CHAR_W-1:0]     char_r, char_nxt;
  logic                  letter_r, letter_nxt;

  logic [KEY_W-1:0]      idx;
  logic [KEY_W:0]        enc_sum, enc_pos;
  logic [KEY_W-1:0]      enc_entry;
  logic [ALPHA-1:0]      hit;
  logic                  any_lo, any_hit;
  logic [KEY_W-1:0]      j_lo, j_hi;
  logic [KEY_W:0]        dec_x;

  assign key = {key_high_r, key_mid_r, key_low_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_mid_r  <= '0;
      key_high_r <= '0;
    end else if (cfg.we) begin
      case (cfg.index)
        REG_KEY_LOW:  key_low_r  <= cfg.data;
        REG_KEY_MID:  key_mid_r  <= cfg.data;
        REG_KEY_HIGH: key_high_r <= cfg.data[HIGH_W-1:0];
        default:      ;
      endcase
    end
  end

  assign pop = !q_stat.empty && (!out_valid_r || out_ch.ready);

  assign idx = KEY_W'(head.char_in - LETTER_A);

  // encrypt: rotated entry at idx is key[(idx + offset) mod 26]
  assign enc_sum   = {1'b0, idx} + {1'b0, head.offset};
  assign enc_pos   = (enc_sum >= 6'(ALPHA)) ? enc_sum - 6'(ALPHA) : enc_sum;
  assign enc_entry = key[enc_pos[KEY_W-1:0]];

  // decrypt: key index j maps to rotated position (j - offset) mod 26.
  // Indices below the offset wrap to the top positions, so they win.
  always_comb begin
    any_lo = 1'b0;
    j_lo   = '0;
    j_hi   = '0;
    for (int j = 0; j < ALPHA; j++) begin
      hit[j] = (key[j] == idx);
      if (hit[j]) j_hi = KEY_W'(j);
      if (hit[j] && (KEY_W'(j) < head.offset)) begin
        j_lo   = KEY_W'(j);
        any_lo = 1'b1;
      end
    end
  end

  assign any_hit = |hit;
  assign dec_x   = any_lo ? ({1'b0, j_lo} + 6'(ALPHA) - {1'b0, head.offset})
                          : ({1'b0, j_hi} - {1'b0, head.offset});

  always_comb begin
    char_nxt   = head.char_in;
    letter_nxt = 1'b0;
    if (head.is_alpha) begin
      if (!head.mode) begin
        char_nxt   = LETTER_A + {3'b000, enc_entry};
        letter_nxt = 1'b1;
      end else if (any_hit) begin
        char_nxt   = LETTER_A + {3'b000, dec_x[KEY_W-1:0]};
        letter_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      char_r   <= char_nxt;
      letter_r <= letter_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_out  = char_r;
  assign out_ch.is_letter = letter_r;

endmodule

// ----- rtl/rotating_key_substitution_cipher.sv -----
// ----------------------------------------------------------------------------
// rotating_key_substitution_cipher
// Progressive substitution cipher on a byte stream, one result per character.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries mode (0 encrypt, 1 decrypt), char_in and restart; a
//   transaction completes when valid and ready are both high. out_ch carries
//   char_out and is_letter under the same handshake, one per input character,
//   in order. Lowercase letters are translated through the 26-entry key,
//   rotated by an offset that advances after every character; anything else
//   passes through with is_letter low. restart zeroes the offset first.
//   The key is loaded through cfg_we/cfg_index/cfg_data while the stream is
//   idle: index 0 letters 0-11, 1 letters 12-23, 2 letters 24-25.
// Timing:
//   From input transaction to result valid, the transaction is first written
//   into the front queue and then, with the output register free, goes
//   through the key lookup into it.
//   Throughput is one character per cycle while out_ch.ready stays high;
//   the key lookup and 26-way compare in the back part are combinational.
// Reset clears the offset, the key and the queue. When the receiver stalls,
//   the result holds, the queue fills and in_ch.ready drops once it is full.
// ----------------------------------------------------------------------------
module rotating_key_substitution_cipher
  import rks_pkg::*;
#(
  parameter int QDEPTH = QDEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rks_in_if.sink                in_ch,
  rks_out_if.source             out_ch
);

  item_t   push_item, head;
  q_stat_t q_stat;
  logic    q_push, q_pop;
  cfg_wr_t cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  rks_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (q_push),
    .item   (push_item)
  );

  rks_queue #(.QDEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head      (head),
    .stat      (q_stat)
  );

  rks_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .head   (head),
    .q_stat (q_stat),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  a_stat_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_pop_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_ch.valid)
    else $error("popped transaction did not reach output register");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == !q_stat.full)
    else $error("input ready disagrees with queue fill");
`endif

endmodule
